>>> rtl/core/avcc_pkg.sv
// Shared types and constants of the AVC decoder configuration record parser.
// Used by the step logic, the result queue and the top level; no dependencies.
`default_nettype none

package avcc_pkg;

    // Largest record accepted; a byte at this position or later is an error.
    localparam int unsigned MAX_RECORD_BYTES = 1048576;
    localparam int unsigned POS_W = $clog2(MAX_RECORD_BYTES) + 1;

    // Fixed field widths of one result item.
    localparam int unsigned KIND_W = 3;
    localparam int unsigned IDX_W  = 8;
    localparam int unsigned OFF_W  = 20;
    localparam int unsigned LEN_W  = 16;

    // Record layout constants.
    localparam int unsigned HEADER_BYTES = 5;
    localparam logic [7:0]  MARK_MASK    = 8'b1110_0000;
    localparam logic [7:0]  COUNT_MASK   = 8'b0001_1111;

    // Result queue geometry.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_SPS_COUNT,
        PH_SPS_LEN_HI,
        PH_SPS_LEN_LO,
        PH_SPS_SKIP,
        PH_PPS_COUNT,
        PH_PPS_LEN_HI,
        PH_PPS_LEN_LO,
        PH_PPS_SKIP,
        PH_TRAILER,
        PH_ERROR
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        K_SPS    = 3'd0,
        K_PPS    = 3'd1,
        K_DONE   = 3'd2,
        K_MARKER = 3'd3,
        K_NO_SPS = 3'd4,
        K_NO_PPS = 3'd5,
        K_TRUNC  = 3'd6,
        K_LONG   = 3'd7
    } kind_t;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        phase_t             phase;
        logic [POS_W-1:0]   position;
        logic [7:0]         entries_left;
        logic [IDX_W-1:0]   current_index;
        logic [7:0]         length_high;
        logic [LEN_W-1:0]   skip_left;
    } state_t;

    // One result item.
    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   entry_index;
        logic [OFF_W-1:0]   byte_offset;
        logic [LEN_W-1:0]   payload_length;
        logic               end_of_run;
    } result_t;

    // Results caused by one byte: up to two, in order.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } step_out_t;

    localparam state_t STATE_RESET = '{phase: PH_HEADER, default: '0};

endpackage

`default_nettype wire

>>> rtl/core/avcc_record_sps_pps_parser_top.sv
// Top level of the AVC decoder configuration record parser: input register,
// parser state, and result queue. Depends on avcc_pkg, avcc_step, avcc_out_queue.
// A byte accepted into the input register is parsed once the result queue has
// room, and its results are written into the queue that drives the master side.
// Throughput: one byte per cycle while the queue has room for two more results;
// a byte that yields two results puts both into the four-entry result queue.
// Reset: rst_n clears the parser state, the input register and the queue.
`default_nettype none

module avcc_record_sps_pps_parser_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,    // [7:0] data_byte
    input  wire logic           s_tlast,    // is_final
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [47:0]         m_tdata,    // [7:0] entry_index, [27:8] byte_offset,
                                            // [43:28] payload_length, [47:44] zero
    output logic [2:0]          m_tuser,    // [2:0] kind
    output logic                m_tlast     // end_of_run
);
    import avcc_pkg::*;

    logic                   in_vld_reg;
    logic                   in_vld_next;
    logic [7:0]             in_byte_reg;
    logic                   in_fin_reg;
    state_t                 state_reg;
    state_t                 state_next;
    step_out_t              step_res;
    logic [Q_CNT_W-1:0]     q_fill;
    logic                   fire;
    logic [1:0]             push_count;
    result_t                out_item;

    // A byte is parsed when the queue has room for both possible results.
    assign fire       = in_vld_reg && (q_fill <= Q_CNT_W'(Q_DEPTH - 2));
    assign s_tready   = !in_vld_reg || fire;
    assign push_count = fire ? step_res.count : 2'd0;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready)
            in_vld_next = 1'b1;
        else if (fire)
            in_vld_next = 1'b0;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_fin_reg  <= s_tlast;
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (fire)
            state_reg <= state_next;
    end

    avcc_step u_step (
        .cur       (state_reg),
        .data_byte (in_byte_reg),
        .is_final  (in_fin_reg),
        .nxt       (state_next),
        .res       (step_res)
    );

    avcc_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (step_res.res0),
        .push1      (step_res.res1),
        .fill       (q_fill),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_item   (out_item)
    );

    assign m_tdata = {4'b0000, out_item.payload_length, out_item.byte_offset,
                      out_item.entry_index};
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.end_of_run;

`ifndef SYNTHESIS
    a_error_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (state_reg.phase == PH_ERROR)) |-> (step_res.count == 2'd0))
        else $error("result produced while in error state");

    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_fin_reg) |=> (state_reg.phase == PH_HEADER) && (state_reg.position == '0))
        else $error("parser did not restart after final byte");

    a_terminal_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ((m_tuser == K_DONE) || (m_tuser == K_TRUNC))) |-> m_tlast)
        else $error("terminal result without end of run");

    a_room_for_results: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (q_fill + Q_CNT_W'(step_res.count) <= Q_CNT_W'(Q_DEPTH)))
        else $error("byte parsed without queue room");
`endif

endmodule

`default_nettype wire

>>> rtl/core/avcc_step.sv
// Combinational next-state and result logic for one record byte.
// Depends on avcc_pkg for the state, phase and result types.
`default_nettype none

module avcc_step (
    input  var avcc_pkg::state_t    cur,
    input  wire logic [7:0]         data_byte,
    input  wire logic               is_final,
    output avcc_pkg::state_t        nxt,
    output avcc_pkg::step_out_t     res
);
    import avcc_pkg::*;

    state_t             st;
    result_t            r_body;
    logic               has_body;
    logic [POS_W-1:0]   pos_inc;
    logic [LEN_W-1:0]   new_len;
    result_t            r_term;
    logic               is_sps_len;
    logic               is_sps_skip;
    logic [LEN_W-1:0]   skip_dec;
    logic [7:0]         left_dec;

    assign pos_inc     = cur.position + POS_W'(1);
    assign new_len     = {cur.length_high, data_byte};
    assign is_sps_len  = (cur.phase == PH_SPS_LEN_LO);
    assign is_sps_skip = (cur.phase == PH_SPS_SKIP);
    assign skip_dec    = cur.skip_left - LEN_W'(1);
    assign left_dec    = cur.entries_left - 8'd1;

    // Body of the step: phase-dependent parsing of the byte.
    always_comb
    begin
        st       = cur;
        r_body   = '0;
        has_body = 1'b0;
        if (cur.phase != PH_ERROR)
        begin
            if (cur.position >= POS_W'(MAX_RECORD_BYTES))
            begin
                r_body.kind = K_LONG;
                has_body    = 1'b1;
                st.phase    = PH_ERROR;
            end
            else
            begin
                st.position = pos_inc;
                unique case (cur.phase)
                    PH_HEADER:
                    begin
                        if (pos_inc >= POS_W'(HEADER_BYTES))
                        begin
                            st.phase = PH_SPS_COUNT;
                        end
                    end
                    PH_SPS_COUNT:
                    begin
                        if ((data_byte & MARK_MASK) != MARK_MASK)
                        begin
                            r_body.kind = K_MARKER;
                            has_body    = 1'b1;
                            st.phase    = PH_ERROR;
                        end
                        else if ((data_byte & COUNT_MASK) == 8'd0)
                        begin
                            r_body.kind = K_NO_SPS;
                            has_body    = 1'b1;
                            st.phase    = PH_ERROR;
                        end
                        else
                        begin
                            st.entries_left  = data_byte & COUNT_MASK;
                            st.current_index = '0;
                            st.phase         = PH_SPS_LEN_HI;
                        end
                    end
                    PH_PPS_COUNT:
                    begin
                        if (data_byte == 8'd0)
                        begin
                            r_body.kind = K_NO_PPS;
                            has_body    = 1'b1;
                            st.phase    = PH_ERROR;
                        end
                        else
                        begin
                            st.entries_left  = data_byte;
                            st.current_index = '0;
                            st.phase         = PH_PPS_LEN_HI;
                        end
                    end
                    PH_SPS_LEN_HI:
                    begin
                        st.length_high = data_byte;
                        st.phase       = PH_SPS_LEN_LO;
                    end
                    PH_PPS_LEN_HI:
                    begin
                        st.length_high = data_byte;
                        st.phase       = PH_PPS_LEN_LO;
                    end
                    PH_SPS_LEN_LO, PH_PPS_LEN_LO:
                    begin
                        st.skip_left          = new_len;
                        r_body.kind           = is_sps_len ? K_SPS : K_PPS;
                        r_body.entry_index    = cur.current_index;
                        r_body.byte_offset    = OFF_W'(pos_inc);
                        r_body.payload_length = new_len;
                        has_body              = 1'b1;
                        if (new_len == '0)
                        begin
                            // Empty entry: it ends at its own length byte.
                            st.entries_left  = left_dec;
                            st.current_index = cur.current_index + IDX_W'(1);
                            if (left_dec == 8'd0)
                                st.phase = is_sps_len ? PH_PPS_COUNT : PH_TRAILER;
                            else
                                st.phase = is_sps_len ? PH_SPS_LEN_HI : PH_PPS_LEN_HI;
                        end
                        else
                        begin
                            st.phase = is_sps_len ? PH_SPS_SKIP : PH_PPS_SKIP;
                        end
                    end
                    PH_SPS_SKIP, PH_PPS_SKIP:
                    begin
                        st.skip_left = skip_dec;
                        if (skip_dec == '0)
                        begin
                            st.entries_left  = left_dec;
                            st.current_index = cur.current_index + IDX_W'(1);
                            if (left_dec == 8'd0)
                                st.phase = is_sps_skip ? PH_PPS_COUNT : PH_TRAILER;
                            else
                                st.phase = is_sps_skip ? PH_SPS_LEN_HI : PH_PPS_LEN_HI;
                        end
                    end
                    default:
                    begin
                        // Trailing bytes after the last PPS are ignored.
                    end
                endcase
            end
        end
    end

    // Final byte: terminal result unless an error was reported, then restart; a body result alone is marked end of run.
    always_comb
    begin
        nxt    = st;
        r_term = '0;
        res    = '0;
        r_term.kind = (st.phase == PH_TRAILER) ? K_DONE : K_TRUNC;
        r_term.end_of_run = 1'b1;
        if (is_final)
        begin
            nxt = STATE_RESET;
        end
        if (is_final && (st.phase != PH_ERROR))
        begin
            if (has_body)
            begin
                res.count = 2'd2;
                res.res0  = r_body;
                res.res1  = r_term;
            end
            else
            begin
                res.count = 2'd1;
                res.res0  = r_term;
            end
        end
        else if (has_body)
        begin
            res.count           = 2'd1;
            res.res0            = r_body;
            res.res0.end_of_run = 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/avcc_out_queue.sv
// Small result queue that takes up to two items a cycle and drives the output stream.
// Depends on avcc_pkg for the result type and queue geometry.
`default_nettype none

module avcc_out_queue (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [1:0]                 push_count,
    input  var avcc_pkg::result_t           push0,
    input  var avcc_pkg::result_t           push1,
    output logic [avcc_pkg::Q_CNT_W-1:0]    fill,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output avcc_pkg::result_t               out_item
);
    import avcc_pkg::*;

    result_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]     wr_ptr_reg;
    logic [Q_PTR_W-1:0]     wr_ptr_next;
    logic [Q_PTR_W-1:0]     rd_ptr_reg;
    logic [Q_PTR_W-1:0]     rd_ptr_next;
    logic [Q_CNT_W-1:0]     count_reg;
    logic [Q_CNT_W-1:0]     count_next;
    logic [Q_PTR_W-1:0]     wr_ptr_1;
    logic                   pop;

    assign fill      = count_reg;
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign wr_ptr_1  = wr_ptr_reg + Q_PTR_W'(1);

    // Pointer and fill-level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
        count_next  = count_reg + Q_CNT_W'(push_count) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage: first item at the write pointer, second just after it.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            if ((push_count != 2'd0) && (wr_ptr_reg == Q_PTR_W'(i)))
                entry_reg[i] <= push0;
            else if ((push_count == 2'd2) && (wr_ptr_1 == Q_PTR_W'(i)))
                entry_reg[i] <= push1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == Q_CNT_W'(Q_DEPTH)) || (wr_ptr_reg == rd_ptr_reg + Q_PTR_W'(count_reg)))
        else $error("result queue pointers disagree with fill level");

    a_push_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_count == 2'd3) |-> 1'b0)
        else $error("illegal push count");
`endif

endmodule

`default_nettype wire
